// File: rtl/grid_dda_column_raycaster_core_macros.svh
// assertion macros shared by the raycaster rtl
`ifndef GRID_DDA_COLUMN_RAYCASTER_CORE_MACROS_SVH
`define GRID_DDA_COLUMN_RAYCASTER_CORE_MACROS_SVH

// same-cycle implication
`define GDDA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GDDA_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/gdda_pkg.sv
// types, constants and helper functions for the grid dda raycaster
`default_nettype none

package gdda_pkg;

   localparam int MAP_DIM     = 8;
   localparam int SCREEN_COLS = 512;
   localparam int SCREEN_ROWS = 256;

   localparam int NCELLS    = MAP_DIM * MAP_DIM;
   localparam int CELL_AW   = $clog2(NCELLS);
   localparam int TILE_W    = 3;
   localparam int CRD_W     = 8;
   localparam int MAX_STEPS = 2 * MAP_DIM + 2;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   localparam int FRAC_W    = 16;
   localparam int XCAM_W    = 25;
   localparam int PROD_W    = XCAM_W + 16;
   localparam int RAY_W     = PROD_W - 14 + 1;
   localparam int FX_W      = FRAC_W + 1;
   localparam int DELTA_W   = 31;
   localparam int DIST_W    = 36;
   localparam int DIVN_W    = 31;
   localparam int HMAX      = 2 * SCREEN_ROWS;
   localparam int H_W       = $clog2(HMAX + 1);
   localparam int HALF_ROWS = SCREEN_ROWS / 2;

   localparam logic [TILE_W-1:0] LAYOUT8 [64] = '{
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1,
      3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd3, 3'd0, 3'd1,
      3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1,
      3'd1, 3'd0, 3'd2, 3'd0, 3'd4, 3'd4, 3'd0, 3'd1,
      3'd1, 3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd1,
      3'd1, 3'd0, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
   };

   typedef enum logic {
      KIND_CAST  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef struct packed {
      logic               kind;
      logic [8:0]         column;
      logic [18:0]        pos_x;
      logic [18:0]        pos_y;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] plane_x;
      logic signed [15:0] plane_y;
      logic [5:0]         cell_index;
      logic [2:0]         cell_value;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  wall_top;
      logic [7:0]  wall_bottom;
      logic [31:0] wall_color;
      logic        hit_side;
      logic [2:0]  hit_tile;
      logic        out_of_bounds;
      logic [8:0]  column_out;
   } rsp_item_type;

   typedef logic [NCELLS-1:0][TILE_W-1:0] tile_array_type;

   function automatic tile_array_type reset_tiles();
      tile_array_type t;
      t = '0;
      for (int r = 0; r < MAP_DIM; r++) begin
         for (int c = 0; c < MAP_DIM; c++) begin
            if (r == 0 || c == 0 || r == MAP_DIM - 1 || c == MAP_DIM - 1) begin
               t[r * MAP_DIM + c] = TILE_W'(1);
            end else if (r < 7 && c < 7) begin
               t[r * MAP_DIM + c] = LAYOUT8[r * 8 + c];
            end
         end
      end
      return t;
   endfunction

   localparam tile_array_type RESET_TILES = reset_tiles();

   function automatic logic [31:0] tile_color(input logic [TILE_W-1:0] t);
      logic [31:0] c;
      unique case (t)
         3'd1:    c = 32'hFF0000FF;
         3'd2:    c = 32'hFF00FF00;
         3'd3:    c = 32'hFFFF0000;
         3'd4:    c = 32'hFFFF00FF;
         default: c = 32'hFF000000;
      endcase
      return c;
   endfunction

   // channel * 0xc0 / 256 == channel * 3 / 4
   function automatic logic [7:0] dim_channel(input logic [7:0] ch);
      logic [9:0] p;
      p = {2'b00, ch} + {1'b0, ch, 1'b0};
      return p[9:2];
   endfunction

   function automatic logic [31:0] dim_color(input logic [31:0] c);
      return {8'hFF, dim_channel(c[23:16]), dim_channel(c[15:8]), dim_channel(c[7:0])};
   endfunction

endpackage

`default_nettype wire

// File: rtl/gdda_tile_mem.sv
// tile map memory with reset layout held by per-entry valid bits
`default_nettype none

module gdda_tile_mem (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               wr_en,
   input  wire logic [gdda_pkg::CELL_AW-1:0]       wr_addr,
   input  wire logic [gdda_pkg::TILE_W-1:0]        wr_data,
   input  wire logic                               rd_en,
   input  wire logic [gdda_pkg::CELL_AW-1:0]       rd_addr,
   output logic      [gdda_pkg::TILE_W-1:0]        rd_data
);

   logic [gdda_pkg::TILE_W-1:0] mem [gdda_pkg::NCELLS];
   logic [gdda_pkg::NCELLS-1:0] valid_ff;
   logic [gdda_pkg::TILE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : gdda_pkg::RESET_TILES[rd_addr];
      end
   end

   // entries not yet written read as the built-in layout
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/gdda_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module gdda_divider (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              go,
   input  wire logic [gdda_pkg::DIVN_W-1:0]       dividend,
   input  wire logic [gdda_pkg::DIST_W-1:0]       divisor,
   output logic                                   done,
   output logic      [gdda_pkg::DIVN_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(gdda_pkg::DIVN_W + 1);

   logic                          busy_ff;
   logic                          done_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic [gdda_pkg::DIVN_W-1:0]   quo_ff;
   logic [gdda_pkg::DIST_W:0]     rem_ff;
   logic [gdda_pkg::DIST_W-1:0]   dvs_ff;
   logic [gdda_pkg::DIST_W:0]     trial;
   logic                          fits;

   assign trial = {rem_ff[gdda_pkg::DIST_W-1:0], quo_ff[gdda_pkg::DIVN_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (go) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial - {1'b0, dvs_ff} : trial;
         quo_ff <= {quo_ff[gdda_pkg::DIVN_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(gdda_pkg::DIVN_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/grid_dda_column_raycaster_core.sv
// top level: cast and map-write sequencer around the tile memory and the shared divider
//
//   channel  ports                        direction  transfer when
//   request  start, busy, req_item        in         start && !busy
//   result   rsp_strobe, rsp_item         out        rsp_strobe (one cycle)
//
// a map write keeps busy high through the S_WRITE state. a cast keeps busy high through three
// serial divides (two reciprocals and the wall height) in the shared divider (start, 31
// quotient bits, done), plus a read of the tile memory per step; a miss or a zero wall
// distance skips the last divide.
// synchronous active-high reset; the map reads as the built-in layout after it.
// the result strobe comes in the first idle cycle and cannot be held off by the receiver.
`default_nettype none

`include "grid_dda_column_raycaster_core_macros.svh"

module grid_dda_column_raycaster_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire gdda_pkg::req_item_type  req_item,
   output logic                         rsp_strobe,
   output gdda_pkg::rsp_item_type       rsp_item
);

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_RAYX, S_RAYY, S_RAYS, S_DIVX, S_DIVXW, S_DIVY, S_DIVYW,
      S_SIDEX, S_SIDEY, S_STEP, S_BOUND, S_CHECK, S_HGO, S_HWAIT
   } state_type;

   localparam int CW    = gdda_pkg::CRD_W;
   localparam int MUL_W = gdda_pkg::FX_W + gdda_pkg::DELTA_W;

   state_type                            state_ff;
   gdda_pkg::req_item_type               req_ff;
   logic signed [gdda_pkg::PROD_W-1:0]   prod_ff;
   logic signed [gdda_pkg::RAY_W-1:0]    rx_ff;
   logic signed [gdda_pkg::RAY_W-1:0]    ry_ff;
   logic [gdda_pkg::DELTA_W-1:0]         dx_ff;
   logic [gdda_pkg::DELTA_W-1:0]         dy_ff;
   logic [gdda_pkg::DIST_W-1:0]          distx_ff;
   logic [gdda_pkg::DIST_W-1:0]          disty_ff;
   logic signed [CW-1:0]                 cx_ff;
   logic signed [CW-1:0]                 cy_ff;
   logic [gdda_pkg::STEP_W-1:0]          steps_ff;
   logic                                 side_ff;
   logic [gdda_pkg::TILE_W-1:0]          tile_ff;
   logic [gdda_pkg::DIST_W-1:0]          perp_ff;
   logic                                 rsp_strobe_ff;
   gdda_pkg::rsp_item_type               rsp_ff;

   logic signed [gdda_pkg::XCAM_W-1:0]   xcam;
   logic [gdda_pkg::RAY_W-1:0]           ax;
   logic [gdda_pkg::RAY_W-1:0]           ay;
   logic                                 vx;
   logic                                 vy;
   logic [gdda_pkg::FX_W-1:0]            fx;
   logic [gdda_pkg::FX_W-1:0]            fy;
   logic                                 step_x;
   logic                                 out_map;
   logic [gdda_pkg::CELL_AW-1:0]         rd_addr;
   logic [gdda_pkg::TILE_W-1:0]          rd_data;
   logic                                 mem_wr_en;
   logic                                 mem_rd_en;
   logic                                 div_go;
   logic [gdda_pkg::DIVN_W-1:0]          div_dividend;
   logic [gdda_pkg::DIST_W-1:0]          div_divisor;
   logic                                 div_done;
   logic [gdda_pkg::DIVN_W-1:0]          div_quotient;
   logic [gdda_pkg::H_W-1:0]             h_val;
   logic signed [gdda_pkg::H_W+1:0]      top_val;
   logic signed [gdda_pkg::H_W+1:0]      bot_val;
   logic [31:0]                          color;

   // camera x = 2*column/cols - 1 in q.14
   assign xcam = $signed(gdda_pkg::XCAM_W'(({15'b0, req_ff.column} << 15)
                  / gdda_pkg::SCREEN_COLS)) - gdda_pkg::XCAM_W'(16384);

   assign ax = rx_ff[gdda_pkg::RAY_W-1] ? gdda_pkg::RAY_W'(-rx_ff) : gdda_pkg::RAY_W'(rx_ff);
   assign ay = ry_ff[gdda_pkg::RAY_W-1] ? gdda_pkg::RAY_W'(-ry_ff) : gdda_pkg::RAY_W'(ry_ff);
   assign vx = rx_ff != '0;
   assign vy = ry_ff != '0;

   // distance to the next grid line in the step direction
   assign fx = rx_ff[gdda_pkg::RAY_W-1] ? {1'b0, req_ff.pos_x[15:0]}
             : gdda_pkg::FX_W'(65536) - {1'b0, req_ff.pos_x[15:0]};
   assign fy = ry_ff[gdda_pkg::RAY_W-1] ? {1'b0, req_ff.pos_y[15:0]}
             : gdda_pkg::FX_W'(65536) - {1'b0, req_ff.pos_y[15:0]};

   assign step_x  = vx && (!vy || distx_ff < disty_ff);
   assign out_map = cx_ff < 0 || cx_ff >= CW'(gdda_pkg::MAP_DIM)
                 || cy_ff < 0 || cy_ff >= CW'(gdda_pkg::MAP_DIM);
   assign rd_addr = gdda_pkg::CELL_AW'(cy_ff * CW'(gdda_pkg::MAP_DIM) + cx_ff);

   assign mem_wr_en = (state_ff == S_WRITE)
                   && ({1'b0, req_ff.cell_index} < 7'(gdda_pkg::NCELLS));
   assign mem_rd_en = (state_ff == S_BOUND) && !out_map;

   always_comb begin
      div_go       = 1'b0;
      div_dividend = gdda_pkg::DIVN_W'(1) << 30;
      div_divisor  = gdda_pkg::DIST_W'(ax);
      unique case (state_ff)
         S_DIVX: div_go = 1'b1;
         S_DIVY: begin
            div_go      = 1'b1;
            div_divisor = gdda_pkg::DIST_W'(ay);
         end
         S_HGO: begin
            div_go       = perp_ff != '0;
            div_dividend = gdda_pkg::DIVN_W'(gdda_pkg::SCREEN_ROWS) << 16;
            div_divisor  = perp_ff;
         end
         default: ;
      endcase
   end

   // wall height, saturated; span around the screen middle
   assign h_val   = (div_quotient > gdda_pkg::DIVN_W'(gdda_pkg::HMAX))
                  ? gdda_pkg::H_W'(gdda_pkg::HMAX) : gdda_pkg::H_W'(div_quotient);
   assign top_val = $signed((gdda_pkg::H_W+2)'(gdda_pkg::HALF_ROWS))
                  - $signed((gdda_pkg::H_W+2)'(h_val >> 1));
   assign bot_val = $signed((gdda_pkg::H_W+2)'(gdda_pkg::HALF_ROWS))
                  + $signed((gdda_pkg::H_W+2)'(h_val >> 1));
   assign color   = gdda_pkg::tile_color(tile_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= (req_item.kind == gdda_pkg::KIND_WRITE) ? S_WRITE : S_RAYX;
               end
            end
            S_WRITE: state_ff <= S_IDLE;
            S_RAYX: begin
               prod_ff  <= gdda_pkg::PROD_W'(req_ff.plane_x * xcam);
               state_ff <= S_RAYY;
            end
            S_RAYY: begin
               rx_ff    <= gdda_pkg::RAY_W'(req_ff.dir_x) + gdda_pkg::RAY_W'(prod_ff >>> 14);
               prod_ff  <= gdda_pkg::PROD_W'(req_ff.plane_y * xcam);
               state_ff <= S_RAYS;
            end
            S_RAYS: begin
               ry_ff    <= gdda_pkg::RAY_W'(req_ff.dir_y) + gdda_pkg::RAY_W'(prod_ff >>> 14);
               state_ff <= S_DIVX;
            end
            S_DIVX: state_ff <= S_DIVXW;
            S_DIVXW: begin
               if (div_done) begin
                  dx_ff    <= vx ? div_quotient : '0;
                  state_ff <= S_DIVY;
               end
            end
            S_DIVY: state_ff <= S_DIVYW;
            S_DIVYW: begin
               if (div_done) begin
                  dy_ff    <= vy ? div_quotient : '0;
                  state_ff <= S_SIDEX;
               end
            end
            S_SIDEX: begin
               distx_ff <= gdda_pkg::DIST_W'((MUL_W'(fx) * MUL_W'(dx_ff)) >> 16);
               state_ff <= S_SIDEY;
            end
            S_SIDEY: begin
               disty_ff <= gdda_pkg::DIST_W'((MUL_W'(fy) * MUL_W'(dy_ff)) >> 16);
               cx_ff    <= CW'(req_ff.pos_x[18:16]);
               cy_ff    <= CW'(req_ff.pos_y[18:16]);
               steps_ff <= '0;
               side_ff  <= 1'b0;
               if (vx || vy) begin
                  state_ff <= S_STEP;
               end else begin
                  rsp_ff        <= '{out_of_bounds: 1'b1, column_out: req_ff.column,
                                     default: '0};
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_STEP: begin
               if (steps_ff == gdda_pkg::STEP_W'(gdda_pkg::MAX_STEPS)) begin
                  rsp_ff        <= '{out_of_bounds: 1'b1, column_out: req_ff.column,
                                     default: '0};
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  if (step_x) begin
                     distx_ff <= distx_ff + gdda_pkg::DIST_W'(dx_ff);
                     cx_ff    <= rx_ff[gdda_pkg::RAY_W-1] ? cx_ff - CW'(1) : cx_ff + CW'(1);
                     side_ff  <= 1'b0;
                  end else begin
                     disty_ff <= disty_ff + gdda_pkg::DIST_W'(dy_ff);
                     cy_ff    <= ry_ff[gdda_pkg::RAY_W-1] ? cy_ff - CW'(1) : cy_ff + CW'(1);
                     side_ff  <= 1'b1;
                  end
                  steps_ff <= steps_ff + gdda_pkg::STEP_W'(1);
                  state_ff <= S_BOUND;
               end
            end
            S_BOUND: begin
               if (out_map) begin
                  rsp_ff        <= '{out_of_bounds: 1'b1, column_out: req_ff.column,
                                     default: '0};
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (rd_data != '0) begin
                  tile_ff  <= rd_data;
                  perp_ff  <= side_ff ? disty_ff - gdda_pkg::DIST_W'(dy_ff)
                                      : distx_ff - gdda_pkg::DIST_W'(dx_ff);
                  state_ff <= S_HGO;
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_HGO: begin
               if (perp_ff == '0) begin
                  rsp_ff.wall_top      <= '0;
                  rsp_ff.wall_bottom   <= 8'(gdda_pkg::SCREEN_ROWS - 1);
                  rsp_ff.wall_color    <= side_ff ? gdda_pkg::dim_color(color) : color;
                  rsp_ff.hit_side      <= side_ff;
                  rsp_ff.hit_tile      <= tile_ff;
                  rsp_ff.out_of_bounds <= 1'b0;
                  rsp_ff.column_out    <= req_ff.column;
                  rsp_strobe_ff        <= 1'b1;
                  state_ff             <= S_IDLE;
               end else begin
                  state_ff <= S_HWAIT;
               end
            end
            S_HWAIT: begin
               if (div_done) begin
                  rsp_ff.wall_top      <= (top_val < 0) ? 8'd0 : 8'(top_val);
                  rsp_ff.wall_bottom   <=
                     (bot_val > (gdda_pkg::H_W+2)'(gdda_pkg::SCREEN_ROWS - 1))
                     ? 8'(gdda_pkg::SCREEN_ROWS - 1) : 8'(bot_val);
                  rsp_ff.wall_color    <= side_ff ? gdda_pkg::dim_color(color) : color;
                  rsp_ff.hit_side      <= side_ff;
                  rsp_ff.hit_tile      <= tile_ff;
                  rsp_ff.out_of_bounds <= 1'b0;
                  rsp_ff.column_out    <= req_ff.column;
                  rsp_strobe_ff        <= 1'b1;
                  state_ff             <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   gdda_tile_mem u_tile_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (req_ff.cell_index),
      .wr_data (req_ff.cell_value),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gdda_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `GDDA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted item left block idle")
   `GDDA_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_strobe, !busy, "result strobe while busy")
   `GDDA_ASSERT_IMP(a_oob_zero, clock, reset, rsp_strobe && rsp_item.out_of_bounds, rsp_item.wall_color == 32'd0 && rsp_item.hit_tile == 3'd0, "miss result carries wall data")
   `GDDA_ASSERT_IMP(a_hit_tile, clock, reset, rsp_strobe && !rsp_item.out_of_bounds, rsp_item.hit_tile != 3'd0, "hit result with empty tile")

endmodule

`default_nettype wire

// File: sim/tb.sv
// testbench for the grid dda column raycaster: map writes and column casts
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam int N_RANDOM   = 730;
   localparam int PAUSE_AT   = 300;
   localparam int DRAIN_WAIT = 300;
   localparam int IDLE_LIMIT = 5000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   gdda_pkg::req_item_type req_item;
   logic                   rsp_strobe;
   gdda_pkg::rsp_item_type rsp_item;

   grid_dda_column_raycaster_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   gdda_pkg::req_item_type pending_q [$];
   gdda_pkg::rsp_item_type expected_spans [$];
   logic [2:0]   tile_cells [gdda_pkg::NCELLS];
   int           sent_count;
   int           fail_count;
   int           idle_cycles;
   int           gap_left;
   bit           calm_mode;
   bit           stim_done;
   bit           taken;

   // cast one column against the current tile map
   function automatic gdda_pkg::rsp_item_type cast_column(input gdda_pkg::req_item_type q);
      gdda_pkg::rsp_item_type r;
      longint xcam, rx, ry, ax, ay, dx, dy, fx, fy, cx, cy, sx, sy, distx, disty, perp, h;
      longint top, bot, br, g, color;
      bit vx, vy, hit, side;
      logic [2:0] tile;
      r = '0;
      r.column_out = q.column;
      xcam = ((longint'(q.column) << 15) / gdda_pkg::SCREEN_COLS) - 16384;
      rx = longint'(q.dir_x) + ((longint'(q.plane_x) * xcam) >>> 14);
      ry = longint'(q.dir_y) + ((longint'(q.plane_y) * xcam) >>> 14);
      ax = rx < 0 ? -rx : rx;
      ay = ry < 0 ? -ry : ry;
      vx = ax != 0;
      vy = ay != 0;
      dx = vx ? (64'd1 << 30) / ax : 0;
      dy = vy ? (64'd1 << 30) / ay : 0;
      fx = q.pos_x[15:0];
      fy = q.pos_y[15:0];
      cx = q.pos_x >> 16;
      cy = q.pos_y >> 16;
      sx = rx < 0 ? -1 : 1;
      sy = ry < 0 ? -1 : 1;
      if (rx >= 0) fx = 65536 - fx;
      if (ry >= 0) fy = 65536 - fy;
      distx = (fx * dx) >> 16;
      disty = (fy * dy) >> 16;
      hit = 0;
      side = 0;
      tile = 0;
      for (int s = 0; s < gdda_pkg::MAX_STEPS && (vx || vy); s++) begin
         if (vx && (!vy || distx < disty)) begin
            distx += dx; cx += sx; side = 0;
         end else begin
            disty += dy; cy += sy; side = 1;
         end
         if (cx < 0 || cx >= gdda_pkg::MAP_DIM || cy < 0 || cy >= gdda_pkg::MAP_DIM) break;
         tile = tile_cells[cy * gdda_pkg::MAP_DIM + cx];
         if (tile != 0) begin
            hit = 1;
            break;
         end
      end
      if (!hit) begin
         r.out_of_bounds = 1'b1;
         return r;
      end
      perp = side ? disty - dy : distx - dx;
      if (perp == 0) h = gdda_pkg::HMAX;
      else begin
         h = (longint'(gdda_pkg::SCREEN_ROWS) << 16) / perp;
         if (h > gdda_pkg::HMAX) h = gdda_pkg::HMAX;
      end
      top = gdda_pkg::HALF_ROWS - h / 2;
      if (top < 0) top = 0;
      bot = gdda_pkg::HALF_ROWS + h / 2;
      if (bot > gdda_pkg::SCREEN_ROWS - 1) bot = gdda_pkg::SCREEN_ROWS - 1;
      case (tile)
         3'd1: color = 64'hFF0000FF;
         3'd2: color = 64'hFF00FF00;
         3'd3: color = 64'hFFFF0000;
         3'd4: color = 64'hFFFF00FF;
         default: color = 64'hFF000000;
      endcase
      if (side) begin
         br = ((color & 64'hFF00FF) * 64'hC0) >> 8;
         g = ((color & 64'h00FF00) * 64'hC0) >> 8;
         color = 64'hFF000000 | (br & 64'hFF00FF) | (g & 64'h00FF00);
      end
      r.wall_top = top[7:0];
      r.wall_bottom = bot[7:0];
      r.wall_color = color[31:0];
      r.hit_side = side;
      r.hit_tile = tile;
      return r;
   endfunction

   // accepted transfers: update the map or queue the expected span
   always @(posedge clock) begin
      if (reset) begin
         foreach (tile_cells[i]) tile_cells[i] = gdda_pkg::RESET_TILES[i];
         taken <= 1'b0;
      end else begin
         taken <= start && !busy;
         if (start && !busy) begin
            if (req_item.kind == gdda_pkg::KIND_WRITE) begin
               if (req_item.cell_index < gdda_pkg::NCELLS)
                  tile_cells[req_item.cell_index] = req_item.cell_value;
            end else begin
               expected_spans.push_back(cast_column(req_item));
            end
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      gdda_pkg::rsp_item_type e;
      if (!reset && rsp_strobe) begin
         if (expected_spans.size() == 0) begin
            $error("unexpected result for column %0d", rsp_item.column_out);
            fail_count++;
         end else begin
            e = expected_spans.pop_front();
            if (rsp_item.wall_top !== e.wall_top) begin
               $error("wall_top exp %0d got %0d", e.wall_top, rsp_item.wall_top);
               fail_count++;
            end
            if (rsp_item.wall_bottom !== e.wall_bottom) begin
               $error("wall_bottom exp %0d got %0d", e.wall_bottom, rsp_item.wall_bottom);
               fail_count++;
            end
            if (rsp_item.wall_color !== e.wall_color) begin
               $error("wall_color exp %h got %h", e.wall_color, rsp_item.wall_color);
               fail_count++;
            end
            if (rsp_item.hit_side !== e.hit_side) begin
               $error("hit_side exp %0d got %0d", e.hit_side, rsp_item.hit_side);
               fail_count++;
            end
            if (rsp_item.hit_tile !== e.hit_tile) begin
               $error("hit_tile exp %0d got %0d", e.hit_tile, rsp_item.hit_tile);
               fail_count++;
            end
            if (rsp_item.out_of_bounds !== e.out_of_bounds) begin
               $error("out_of_bounds exp %0d got %0d", e.out_of_bounds,
                      rsp_item.out_of_bounds);
               fail_count++;
            end
            if (rsp_item.column_out !== e.column_out) begin
               $error("column_out exp %0d got %0d", e.column_out, rsp_item.column_out);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // request driver, changes on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (start && !taken) begin
         // hold the item until it is taken
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_q.size() == 0
                   || (sent_count == PAUSE_AT && expected_spans.size() != 0)) begin
         start <= 1'b0;
      end else begin
         req_item <= pending_q.pop_front();
         start <= 1'b1;
         sent_count <= sent_count + 1;
         if (sent_count % 100 == 0) calm_mode <= ($urandom_range(0, 3) == 0);
         if (calm_mode || $urandom_range(0, 2) != 0) gap_left <= 0;
         else if ($urandom_range(0, 9) < 8) gap_left <= int'($urandom_range(1, 3));
         else gap_left <= int'($urandom_range(20, 60));
      end
   end

   function automatic gdda_pkg::req_item_type cast_item(input int col, input int px,
                                                        input int py, input int drx,
                                                        input int dry, input int plx,
                                                        input int ply);
      gdda_pkg::req_item_type q;
      q = '0;
      q.kind = gdda_pkg::KIND_CAST;
      q.column = 9'(col);
      q.pos_x = 19'(px);
      q.pos_y = 19'(py);
      q.dir_x = 16'(drx);
      q.dir_y = 16'(dry);
      q.plane_x = 16'(plx);
      q.plane_y = 16'(ply);
      return q;
   endfunction

   function automatic gdda_pkg::req_item_type write_item(input int idx, input int val);
      gdda_pkg::req_item_type q;
      q = '0;
      q.kind = gdda_pkg::KIND_WRITE;
      q.cell_index = 6'(idx);
      q.cell_value = 3'(val);
      return q;
   endfunction

   initial begin
      gdda_pkg::req_item_type q;
      int roll;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      sent_count = 0;
      fail_count = 0;
      idle_cycles = 0;
      calm_mode = 0;
      stim_done = 0;
      // cardinal directions and screen edges
      pending_q.push_back(cast_item(256, 32'h38000, 32'h38000, 16384, 0, 0, 10923));
      pending_q.push_back(cast_item(0, 32'h38000, 32'h38000, -16384, 0, 0, -10923));
      pending_q.push_back(cast_item(511, 32'h38000, 32'h38000, 0, 16384, 10923, 0));
      pending_q.push_back(cast_item(100, 32'h18000, 32'h18000, 0, -16384, -32768, 0));
      // both ray components zero
      pending_q.push_back(cast_item(256, 32'h38000, 32'h38000, 0, 0, 32767, -32768));
      // zero perpendicular distance: on a grid line facing the border
      pending_q.push_back(cast_item(256, 32'h10000, 32'h38000, -16384, 0, 0, 0));
      // position and direction extremes
      pending_q.push_back(cast_item(511, 524287, 524287, 32767, 32767, 32767, 32767));
      pending_q.push_back(cast_item(0, 0, 0, -32768, -32768, -32768, -32768));
      // odd tile codes, then a hole in the border to leave the map
      pending_q.push_back(write_item(27, 5));
      pending_q.push_back(write_item(28, 7));
      pending_q.push_back(write_item(19, 6));
      pending_q.push_back(cast_item(256, 32'h18000, 32'h38000, 16384, 0, 0, 0));
      pending_q.push_back(cast_item(256, 32'h38000, 32'h18000, 0, 16384, 0, 0));
      pending_q.push_back(write_item(31, 0));
      pending_q.push_back(write_item(63, 2));
      pending_q.push_back(write_item(0, 4));
      pending_q.push_back(cast_item(256, 32'h58000, 32'h38000, 16384, 0, 0, 0));
      pending_q.push_back(write_item(31, 1));
      pending_q.push_back(write_item(27, 0));
      pending_q.push_back(write_item(28, 0));
      pending_q.push_back(write_item(19, 0));
      for (int i = 0; i < N_RANDOM; i++) begin
         roll = int'($urandom_range(0, 99));
         q = gdda_pkg::req_item_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
         if (roll < 10) begin
            // unconstrained noise
         end else if (roll < 30) begin
            q.kind = gdda_pkg::KIND_WRITE;
            if ($urandom_range(0, 2) != 0) begin
               q.cell_index = 6'($urandom_range(1, 6) * 8 + $urandom_range(1, 6));
               q.cell_value = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
            end
         end else begin
            q.kind = gdda_pkg::KIND_CAST;
            q.pos_x = 19'($urandom_range(32'h10000, 32'h6FFFF));
            q.pos_y = 19'($urandom_range(32'h10000, 32'h6FFFF));
            if ($urandom_range(0, 1)) begin
               q.dir_x = 16'(int'($urandom_range(0, 32767)) - 16384);
               q.dir_y = 16'(int'($urandom_range(0, 32767)) - 16384);
               q.plane_x = 16'(int'($urandom_range(0, 21845)) - 10923);
               q.plane_y = 16'(int'($urandom_range(0, 21845)) - 10923);
            end
         end
         pending_q.push_back(q);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/gdda_pkg.sv
rtl/gdda_tile_mem.sv
rtl/gdda_divider.sv
rtl/grid_dda_column_raycaster_core.sv
sim/tb.sv
